// ===== rtl/bbf_pkg.sv =====
// ----------------------------------------------------------------------------
// bbf_pkg
// Shared types and constants for the bounded byte FIFO.
// ----------------------------------------------------------------------------
package bbf_pkg;

  // Default store depth in bytes
  localparam int unsigned BBF_DEPTH = 1024;

  // Width of the count-like fields (capacity, count, fill, space)
  localparam int unsigned CNT_W = 11;

  // Capacity register value after reset
  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  // Command codes
  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_POP   = 3'd3,
    CMD_END   = 3'd4
  } bbf_cmd_t;

  // Input beat
  typedef struct packed {
    logic [2:0]       command;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] count;
  } bbf_in_t;

  // Result beat
  typedef struct packed {
    logic [7:0]       data_out;
    logic             data_valid;
    logic             accepted;
    logic [CNT_W-1:0] fill_level;
    logic [CNT_W-1:0] space_left;
    logic             stream_closed;
    logic             end_of_stream;
    logic [31:0]      bytes_written_total;
    logic [31:0]      bytes_read_total;
  } bbf_out_t;

endpackage

// ===== rtl/bounded_byte_fifo_top.sv =====
// ----------------------------------------------------------------------------
// bounded_byte_fifo_top
// Byte FIFO with a programmable capacity of at most DEPTH bytes.
// ----------------------------------------------------------------------------
// Result: the result beat is valid in the cycle after its input beat is taken.
// Throughput: one item per cycle while the result channel is not stalled; the store
//   has one write and one read port, and all pointer math is done in the accept cycle.
// Reset: synchronous, active low; pointers, fill, totals and the ended flag
//   clear, capacity returns to 1024. Store contents stay undefined and get
//   no clearing pass, so items are taken from the first cycle after reset.
module bounded_byte_fifo_top #(
  parameter int unsigned DEPTH = bbf_pkg::BBF_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bbf_pkg::bbf_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bbf_pkg::bbf_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bbf_pkg::CNT_W-1:0] cfg_data
);

  import bbf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  // Control and status
  bbf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Byte store
  bbf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/bbf_ram.sv =====
// ----------------------------------------------------------------------------
// bbf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbf_ctrl
// Pointer, occupancy and total counters, command decode, result register.
// ----------------------------------------------------------------------------
module bbf_ctrl #(
  parameter int unsigned DEPTH = bbf_pkg::BBF_DEPTH,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  bbf_pkg::bbf_in_t        in_data,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output bbf_pkg::bbf_out_t       out_data,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [bbf_pkg::CNT_W-1:0] cfg_data,
  // store
  output logic                    ram_we,
  output logic [PTR_W-1:0]        ram_waddr,
  output logic [7:0]              ram_wdata,
  output logic                    ram_re,
  output logic [PTR_W-1:0]        ram_raddr,
  input  logic [7:0]              ram_rdata
);

  import bbf_pkg::*;

  localparam int unsigned SUM_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam int unsigned DEPTH_SAT = (DEPTH > 2047) ? 2047 : DEPTH;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH_SAT);
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

  // Pointer plus offset, wrapped once (offset never exceeds DEPTH)
  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] p, logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(n);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[PTR_W-1:0];
  endfunction

  logic [CNT_W-1:0] capacity_r;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic             ended_r, ended_nxt;
  logic [31:0]      wr_total_r, wr_total_nxt;
  logic [31:0]      rd_total_r, rd_total_nxt;
  logic             out_valid_r;
  bbf_out_t         res_r, res_nxt;

  logic             accept;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] pop_n;
  logic             peek_hit;
  logic             wr_ok;

  // Handshake
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Capacity saturated to the store depth
  assign cap_eff = (capacity_r > DEPTH_C) ? DEPTH_C : capacity_r;

  assign pop_n    = (in_data.count < occ_r) ? in_data.count : occ_r;
  assign peek_hit = in_data.count < occ_r;
  assign wr_ok    = occ_r < cap_eff;

  // Command decode and next state
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    occ_nxt      = occ_r;
    ended_nxt    = ended_r;
    wr_total_nxt = wr_total_r;
    rd_total_nxt = rd_total_r;
    ram_we       = 1'b0;
    ram_raddr    = head_r;
    res_nxt      = '0;
    case (in_data.command)
      CMD_WRITE: begin
        if (wr_ok) begin
          ram_we           = accept;
          tail_nxt         = wrap_add(tail_r, CNT_W'(1));
          occ_nxt          = occ_r + 1'b1;
          wr_total_nxt     = wr_total_r + 32'd1;
          res_nxt.accepted = 1'b1;
        end
      end
      CMD_READ: begin
        if (occ_r != '0) begin
          res_nxt.data_valid = 1'b1;
          head_nxt           = wrap_add(head_r, CNT_W'(1));
          occ_nxt            = occ_r - 1'b1;
          rd_total_nxt       = rd_total_r + 32'd1;
        end
      end
      CMD_PEEK: begin
        if (peek_hit) begin
          res_nxt.data_valid = 1'b1;
          ram_raddr          = wrap_add(head_r, in_data.count);
        end
      end
      CMD_POP: begin
        head_nxt     = wrap_add(head_r, pop_n);
        occ_nxt      = occ_r - pop_n;
        rd_total_nxt = rd_total_r + 32'(pop_n);
      end
      CMD_END: begin
        ended_nxt = 1'b1;
      end
      default: begin
      end
    endcase
    // status after the command
    res_nxt.fill_level          = occ_nxt;
    res_nxt.space_left          = (occ_nxt < cap_eff) ? (cap_eff - occ_nxt) : '0;
    res_nxt.stream_closed       = ended_nxt;
    res_nxt.end_of_stream       = ended_nxt & (occ_nxt == '0);
    res_nxt.bytes_written_total = wr_total_nxt;
    res_nxt.bytes_read_total    = rd_total_nxt;
  end

  assign ram_waddr = tail_r;
  assign ram_wdata = in_data.data_byte;
  assign ram_re    = accept;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  // FIFO state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      occ_r      <= '0;
      ended_r    <= 1'b0;
      wr_total_r <= '0;
      rd_total_r <= '0;
    end else if (accept) begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      occ_r      <= occ_nxt;
      ended_r    <= ended_nxt;
      wr_total_r <= wr_total_nxt;
      rd_total_r <= rd_total_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  // Read data joins the status here; zero when no byte was returned
  always_comb begin
    out_data          = res_r;
    out_data.data_out = res_r.data_valid ? ram_rdata : 8'd0;
  end
  assign out_valid = out_valid_r;

  // Checks
  logic [PTR_W-1:0] tail_chk;
  assign tail_chk = wrap_add(head_r, occ_r);

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_C)
    else $error("occupancy above store depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r == tail_chk)
    else $error("tail pointer out of step with head and occupancy");

  a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |=> ended_r)
    else $error("ended flag cleared");

  a_eos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.end_of_stream |-> res_r.stream_closed && res_r.fill_level == '0)
    else $error("end of stream with data held or input open");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.accepted && res_r.data_valid))
    else $error("write and read flagged in one result");

endmodule
